// ===== hdl/circular_deque_defines.svh =====
// Assertion macros for the circular deque.
// CD_ASSERT checks on every rising clock edge outside reset, CD_ASSERT_ALWAYS also during reset.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS
`define CD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CD_ASSERT(lbl, prop, msg)
`define CD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/cd_pkg.sv =====
`timescale 1ns / 1ps

package cd_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 4;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Broadcast from the control to every cell of the row
  typedef struct packed {
    logic fire;  // command accepted and not rejected
    cmd_e cmd;
  } cell_ctrl_t;

endpackage

// ===== hdl/cd_cell.sv =====
`timescale 1ns / 1ps

// One slot of the deque row. Slot 0 holds the front entry; entries sit at
// slots 0 .. count-1 with no gaps.
module cd_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 4
) (
  input  logic                          clk_i,
  input  cd_pkg::cell_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic [cd_pkg::DATA_W-1:0]     push_value_i,
  input  logic [cd_pkg::DATA_W-1:0]     left_i,   // from slot IDX-1
  input  logic [cd_pkg::DATA_W-1:0]     right_i,  // from slot IDX+1
  output logic [cd_pkg::DATA_W-1:0]     value_o,
  output logic [cd_pkg::DATA_W-1:0]     tap_o     // own value when this slot is the back
);

  logic [cd_pkg::DATA_W-1:0] value_q;
  logic [cd_pkg::DATA_W-1:0] value_d;
  logic                      at_back;
  logic                      at_fill;

  assign at_fill = (count_i == CNT_W'(IDX));
  assign at_back = ((count_i - CNT_W'(1)) == CNT_W'(IDX));

  // Next slot value: load, shift toward the back, shift toward the front, or hold
  always_comb begin
    value_d = value_q;
    if (ctrl_i.fire) begin
      unique case (ctrl_i.cmd)
        cd_pkg::CMD_PUSH_BACK: begin
          if (at_fill) value_d = push_value_i;
        end
        cd_pkg::CMD_PUSH_FRONT: begin
          value_d = (IDX == 0) ? push_value_i : left_i;
        end
        cd_pkg::CMD_POP_FRONT: begin
          value_d = right_i;
        end
        cd_pkg::CMD_POP_BACK: begin
          value_d = value_q;
        end
        default: begin
          value_d = value_q;
        end
      endcase
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tap_o   = at_back ? value_q : '0;

endmodule

// ===== hdl/circular_deque.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+----------------------------------------
// in      | input     | in_valid_i/in_stall_o | command_i, push_value_i
// out     | output    | out_valid_o/out_stall_i | status_o, popped_value_o, fill_count_o
//
// Each command updates the row of slot cells and loads the result register at the
// accepting edge; a new command can follow every cycle while in_stall_o is low.
// The back-slot read is an OR tree over the cell taps.
// Reset clears the fill count and result valid; slot contents stay undefined.
// While a result waits under out_stall_i, in_stall_o is held high.
module circular_deque #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] popped_value_o,
  output logic [3:0]         fill_count_o
);

  `include "circular_deque_defines.svh"

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned DW    = cd_pkg::DATA_W;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q;
  cd_pkg::status_e     status_q, status_d;
  logic [DW-1:0]       popped_q, popped_d;

  logic                accept;
  cd_pkg::cmd_e        cmd;
  logic                is_push;
  logic                full;
  logic                empty;
  cd_pkg::cell_ctrl_t  ctrl;

  logic [DW-1:0]       cell_val [CAPACITY];
  logic [DW-1:0]       cell_tap [CAPACITY];
  logic [DW-1:0]       back_val;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd        = cd_pkg::cmd_e'(command_i);
  assign is_push    = (cmd == cd_pkg::CMD_PUSH_BACK) || (cmd == cd_pkg::CMD_PUSH_FRONT);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);

  // Status and broadcast to the cells
  always_comb begin
    status_d = cd_pkg::ST_DONE;
    if (is_push && full)   status_d = cd_pkg::ST_OVERFLOW;
    if (!is_push && empty) status_d = cd_pkg::ST_UNDERFLOW;
    ctrl.fire = accept && (status_d == cd_pkg::ST_DONE);
    ctrl.cmd  = cmd;
  end

  // Row of slot cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_w;
    logic [DW-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_val[i+1];
    end
    cd_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .push_value_i (push_value_i),
      .left_i       (left_w),
      .right_i      (right_w),
      .value_o      (cell_val[i]),
      .tap_o        (cell_tap[i])
    );
  end

  // Back entry: only the back cell drives a nonzero tap
  always_comb begin
    back_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_val = back_val | cell_tap[i];
    end
  end

  // Popped value and next fill count
  always_comb begin
    popped_d = '0;
    count_d  = count_q;
    if (ctrl.fire) begin
      unique case (cmd)
        cd_pkg::CMD_PUSH_BACK,
        cd_pkg::CMD_PUSH_FRONT: count_d = count_q + CNT_W'(1);
        cd_pkg::CMD_POP_FRONT: begin
          popped_d = cell_val[0];
          count_d  = count_q - CNT_W'(1);
        end
        cd_pkg::CMD_POP_BACK: begin
          popped_d = back_val;
          count_d  = count_q - CNT_W'(1);
        end
        default: count_d = count_q;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign fill_count_o   = cd_pkg::FILL_W'(count_q);

  // Checks
  `CD_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY), "fill count beyond capacity")
  `CD_ASSERT(a_overflow_hold, accept && is_push && full |=> count_q == $past(count_q),
             "overflow changed the fill count")
  `CD_ASSERT(a_pop_dec, ctrl.fire && !is_push |=> count_q == $past(count_q) - CNT_W'(1),
             "successful pop did not decrement the fill count")
  `CD_ASSERT(a_underflow_zero,
             out_valid_q && status_q == cd_pkg::ST_UNDERFLOW |-> popped_q == '0,
             "underflow result carries a nonzero value")

endmodule

// ===== bench/tb_circular_deque.sv =====
`timescale 1ns / 1ps

module tb_circular_deque;

  localparam int unsigned DEPTH      = 8;
  localparam int          DIR_ROWS   = 25;
  localparam int          RAND_ITEMS = 525;
  localparam int          SHOW_MAX   = 10;

  typedef struct packed {
    cd_pkg::status_e    status;
    logic signed [31:0] popped;
    logic [3:0]         fill;
  } deque_result_t;

  // One directed command; res is only used when fixed is set
  typedef struct packed {
    cd_pkg::cmd_e       cmd;
    logic signed [31:0] value;
    logic               fixed;
    deque_result_t      res;
  } stim_row_t;

  localparam deque_result_t NO_RES = '{cd_pkg::ST_DONE, 32'sh0, 4'd0};

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         command_i;
  logic signed [31:0] push_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic signed [31:0] popped_value_o;
  logic [3:0]         fill_count_o;

  // Predictor state
  logic signed [31:0] slot_q [DEPTH];
  int unsigned        head_idx;
  int unsigned        tail_idx;
  int unsigned        occupancy;

  deque_result_t      pending_results [$];
  logic               cur_fixed;
  deque_result_t      cur_fixed_res;

  int unsigned        mismatch_cnt;
  int unsigned        result_cnt;
  int unsigned        n_push, n_pop, n_overflow, n_underflow, n_full;

  // Receiver control, owned by the sender
  int unsigned        hold_len;
  logic               hold_active;
  logic               rx_quiet;

  stim_row_t          dir_rows [DIR_ROWS];

  circular_deque #(
    .CAPACITY(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .fill_count_o  (fill_count_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop
  initial begin
    #3ms;
    $display("tb_circular_deque: errors");
    $finish;
  end

  function automatic int unsigned wrap_inc(int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned wrap_dec(int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Apply one command to the predictor state and return its result
  function automatic deque_result_t predict_deque_op(cd_pkg::cmd_e c, logic signed [31:0] v);
    deque_result_t res;
    res = NO_RES;
    if (c == cd_pkg::CMD_PUSH_BACK || c == cd_pkg::CMD_PUSH_FRONT) begin
      if (occupancy >= DEPTH) begin
        res.status = cd_pkg::ST_OVERFLOW;
        n_overflow++;
      end else begin
        if (c == cd_pkg::CMD_PUSH_BACK) begin
          slot_q[tail_idx] = v;
          tail_idx = wrap_inc(tail_idx);
        end else begin
          head_idx = wrap_dec(head_idx);
          slot_q[head_idx] = v;
        end
        occupancy++;
        n_push++;
        if (occupancy == DEPTH) n_full++;
      end
    end else begin
      if (occupancy == 0) begin
        res.status = cd_pkg::ST_UNDERFLOW;
        n_underflow++;
      end else begin
        if (c == cd_pkg::CMD_POP_FRONT) begin
          res.popped = slot_q[head_idx];
          head_idx = wrap_inc(head_idx);
        end else begin
          tail_idx = wrap_dec(tail_idx);
          res.popped = slot_q[tail_idx];
        end
        occupancy--;
        n_pop++;
      end
    end
    res.fill = occupancy[3:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom_range(15);
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Transfer tracking: score results first, then log the accepted command
  always @(posedge clk_i) begin : result_checker
    deque_result_t want;
    deque_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        result_cnt++;
        got = '{cd_pkg::status_e'(status_o), popped_value_o, fill_count_o};
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_MAX)
            $display("%0t: result with nothing pending: status %0d value %0d fill %0d",
                     $realtime, status_o, popped_value_o, fill_count_o);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.popped !== want.popped ||
              got.fill !== want.fill) begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOW_MAX)
              $display("%0t: mismatch: status %0d/%0d value %0d/%0d fill %0d/%0d (exp/act)",
                       $realtime, want.status, status_o, want.popped, popped_value_o,
                       want.fill, fill_count_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = predict_deque_op(cd_pkg::cmd_e'(command_i), push_value_i);
        pending_results.push_back(cur_fixed ? cur_fixed_res : want);
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and long holds on request
  initial begin : receiver
    int unsigned n;
    out_stall_i = 1'b0;
    hold_active = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        hold_active = 1'b1;
        out_stall_i = 1'b1;
        repeat (n - 1) @(negedge clk_i);
        hold_active = 1'b0;
      end else if (rx_quiet) begin
        out_stall_i = 1'b0;
      end else begin
        n = pick_idle_len();
        if (n == 0) begin
          out_stall_i = 1'b0;
        end else begin
          out_stall_i = 1'b1;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Offer one command at the falling edge, hold it until the transfer
  task automatic send_cmd(input cd_pkg::cmd_e c, input logic signed [31:0] v,
                          input logic fixed, input deque_result_t r);
    command_i     = c;
    push_value_i  = v;
    cur_fixed     = fixed;
    cur_fixed_res = r;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      in_valid_i   = 1'b0;
      push_value_i = $urandom;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Stimulus
  initial begin : sender
    int unsigned  seg_left;
    int unsigned  push_pct;
    int unsigned  burst_left;
    logic         tx_quiet;
    cd_pkg::cmd_e c;

    in_valid_i    = 1'b0;
    command_i     = cd_pkg::CMD_PUSH_BACK;
    push_value_i  = '0;
    cur_fixed     = 1'b0;
    cur_fixed_res = NO_RES;
    rx_quiet      = 1'b1;
    hold_len      = 0;
    mismatch_cnt  = 0;
    result_cnt    = 0;
    n_push = 0; n_pop = 0; n_overflow = 0; n_underflow = 0; n_full = 0;
    head_idx  = 0;
    tail_idx  = 0;
    occupancy = 0;
    foreach (slot_q[i]) slot_q[i] = '0;

    dir_rows = '{
      // empty after reset: both pops underflow
      '{cd_pkg::CMD_POP_FRONT,  32'sh0,         1'b1,
        '{cd_pkg::ST_UNDERFLOW, 32'sh0, 4'd0}},
      '{cd_pkg::CMD_POP_BACK,   32'shDEAD_BEEF, 1'b1,
        '{cd_pkg::ST_UNDERFLOW, 32'sh0, 4'd0}},
      // single entry in and out from each end
      '{cd_pkg::CMD_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1,
        '{cd_pkg::ST_DONE, 32'sh0, 4'd1}},
      '{cd_pkg::CMD_POP_FRONT,  32'sh0,         1'b1,
        '{cd_pkg::ST_DONE, 32'sh7FFF_FFFF, 4'd0}},
      // one entry in at the front, out at the back
      '{cd_pkg::CMD_PUSH_FRONT, 32'sh8000_0000, 1'b1,
        '{cd_pkg::ST_DONE, 32'sh0, 4'd1}},
      '{cd_pkg::CMD_POP_BACK,   32'sh1234_5678, 1'b1,
        '{cd_pkg::ST_DONE, 32'sh8000_0000, 4'd0}},
      // fill from both ends
      '{cd_pkg::CMD_PUSH_BACK,  32'shFFFF_FFFF, 1'b0, NO_RES},
      '{cd_pkg::CMD_PUSH_FRONT, 32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_PUSH_BACK,  32'sh5555_5555, 1'b0, NO_RES},
      '{cd_pkg::CMD_PUSH_FRONT, 32'shAAAA_AAAA, 1'b0, NO_RES},
      '{cd_pkg::CMD_PUSH_BACK,  32'sh1,         1'b0, NO_RES},
      '{cd_pkg::CMD_PUSH_FRONT, 32'sh8000_0000, 1'b0, NO_RES},
      '{cd_pkg::CMD_PUSH_BACK,  32'sh7FFF_FFFF, 1'b0, NO_RES},
      '{cd_pkg::CMD_PUSH_FRONT, 32'sh0F0F_0F0F, 1'b0, NO_RES},
      // full: both pushes overflow
      '{cd_pkg::CMD_PUSH_BACK,  32'sh1111_1111, 1'b1,
        '{cd_pkg::ST_OVERFLOW, 32'sh0, 4'd8}},
      '{cd_pkg::CMD_PUSH_FRONT, 32'sh2222_2222, 1'b1,
        '{cd_pkg::ST_OVERFLOW, 32'sh0, 4'd8}},
      // drain from alternating ends
      '{cd_pkg::CMD_POP_FRONT,  32'shFFFF_FFFF, 1'b0, NO_RES},
      '{cd_pkg::CMD_POP_BACK,   32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_POP_FRONT,  32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_POP_BACK,   32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_POP_FRONT,  32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_POP_BACK,   32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_POP_FRONT,  32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_POP_BACK,   32'sh0,         1'b0, NO_RES},
      '{cd_pkg::CMD_POP_BACK,   32'sh0,         1'b1,
        '{cd_pkg::ST_UNDERFLOW, 32'sh0, 4'd0}}
    };

    // Reset
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows, back to back with the receiver open
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].res);
    idle_for(1);
    wait_drained();

    // Random part: segments that lean toward filling, draining or neither
    seg_left   = 0;
    push_pct   = 50;
    burst_left = 0;
    tx_quiet   = 1'b0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(30, 8);
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        tx_quiet = ($urandom_range(3) == 0);
        rx_quiet = ($urandom_range(3) == 0);
      end
      seg_left--;

      // Long receiver hold while commands keep coming
      if (i == 120 || i == 400) begin
        idle_for(1);
        hold_len = 60;
        while (!hold_active) @(negedge clk_i);
        burst_left = 16;
      end
      // Sender pause until every result is back
      if (i == 260) begin
        idle_for(1);
        wait_drained();
      end

      if ($urandom_range(99) < push_pct)
        c = $urandom_range(1) ? cd_pkg::CMD_PUSH_FRONT : cd_pkg::CMD_PUSH_BACK;
      else
        c = $urandom_range(1) ? cd_pkg::CMD_POP_BACK : cd_pkg::CMD_POP_FRONT;
      send_cmd(c, pick_value(), 1'b0, NO_RES);

      if (burst_left > 0) burst_left--;
      else if (!tx_quiet) idle_for(pick_idle_len());
    end
    in_valid_i = 1'b0;

    // Let the last results come out
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("%0d results checked: %0d pushes, %0d pops, %0d overflows, %0d underflows",
             result_cnt, n_push, n_pop, n_overflow, n_underflow);
    $display("store reached full %0d times; %0d mismatches", n_full, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_circular_deque: clean");
    end else begin
      $display("tb_circular_deque: errors");
    end
    $finish;
  end

endmodule

// ===== circular_deque.f =====
+incdir+hdl
hdl/cd_pkg.sv
hdl/cd_cell.sv
hdl/circular_deque.sv
bench/tb_circular_deque.sv
